FILE: rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the character LCD nibble writer
// Phase codes, request codes, delay lengths and the power-up tables.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  localparam int unsigned US_W   = 15;  // microsecond countdown width
  localparam int unsigned TPU_W  = 8;   // ticks-per-microsecond width
  localparam int unsigned STEP_W = 4;   // init step counter width

  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(80);

  // Delay lengths in microseconds
  localparam logic [US_W-1:0] US_E_HIGH     = US_W'(2);
  localparam logic [US_W-1:0] US_E_LOW      = US_W'(50);
  localparam logic [US_W-1:0] US_CMD_SHORT  = US_W'(50);
  localparam logic [US_W-1:0] US_CMD_LONG   = US_W'(2000);
  localparam logic [US_W-1:0] US_RAW_SETTLE = US_W'(5000);
  localparam logic [US_W-1:0] US_POWER_UP   = US_W'(30000);
  localparam logic [US_W-1:0] US_INIT_TAIL  = US_W'(2000);
  localparam logic [US_W-1:0] US_NONE       = '0;

  // Commands that need the long execution wait
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  // Init step numbers
  localparam logic [STEP_W-1:0] STEP_NONE      = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_POWER_UP  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_RAW_FIRST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_RAW_LAST  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_CMD_FIRST = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_CMD_LAST  = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_TAIL      = STEP_W'(10);

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_DATA = 2'd2,
    REQ_INIT = 2'd3
  } req_code_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_BYTE_EH   = 7'b0000010,
    PH_BYTE_EL   = 7'b0000100,
    PH_CMD_WAIT  = 7'b0001000,
    PH_INIT_WAIT = 7'b0010000,
    PH_RAW_EH    = 7'b0100000,
    PH_RAW_EL    = 7'b1000000
  } phase_t;

  // Timer control from the sequencer for one transfer
  typedef struct packed {
    logic            step;  // count one tick of the running phase
    logic            load;  // start a new phase
    logic [US_W-1:0] us;    // length of the new phase
  } tmr_ctl_t;

  // Power-up command bytes, index 0..3
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  // Power-up bare nibbles, index 0..3
  function automatic logic [3:0] init_nib(input logic [1:0] idx);
    logic [3:0] n;
    case (idx)
      2'd3:    n = 4'h2;
      default: n = 4'h3;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/lcdnw_ifs.sv
// ----------------------------------------------------------------------------
// lcdnw_ifs: valid/ready channels of the character LCD nibble writer
// Request channel, result channel and the rate register write channel.
// ----------------------------------------------------------------------------
interface lcdnw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] byte_value;

  modport source (output valid, req_type, byte_value, input ready);
  modport sink   (input valid, req_type, byte_value, output ready);
endinterface

interface lcdnw_res_if;
  logic       valid;
  logic       ready;
  logic       reg_select_pin;
  logic       enable_pin;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, reg_select_pin, enable_pin, data_nibble, busy_res,
                  rejected, input ready);
  modport sink   (input valid, reg_select_pin, enable_pin, data_nibble, busy_res,
                  rejected, output ready);
endinterface

interface lcdnw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] ticks_per_microsecond;

  modport source (output valid, ticks_per_microsecond, input ready);
  modport sink   (input valid, ticks_per_microsecond, output ready);
endinterface

FILE: rtl/lcdnw_us_timer.sv
// ----------------------------------------------------------------------------
// lcdnw_us_timer: microsecond phase timer
// Prescales ticks into microseconds and counts a phase length down to zero.
// ----------------------------------------------------------------------------
module lcdnw_us_timer
  import lcdnw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tmr_ctl_t         ctl,
  input  logic [TPU_W-1:0] tpu,
  output logic             expired
);

  logic [TPU_W-1:0] prescaler;
  logic [US_W-1:0]  countdown;
  logic [TPU_W-1:0] prescaler_inc;
  logic [TPU_W-1:0] tpu_eff;
  logic             us_tick;
  logic [TPU_W-1:0] prescaler_stepped;
  logic [US_W-1:0]  countdown_stepped;

  // A rate of zero acts as one
  assign tpu_eff       = (tpu == '0) ? TPU_W'(1) : tpu;
  assign prescaler_inc = prescaler + TPU_W'(1);
  assign us_tick       = (prescaler_inc >= tpu_eff);

  assign prescaler_stepped = us_tick ? '0 : prescaler_inc;
  assign countdown_stepped = (us_tick && countdown != '0) ? countdown - US_W'(1)
                                                          : countdown;
  assign expired = (countdown_stepped == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
      countdown <= '0;
    end else if (ctl.load) begin
      prescaler <= '0;
      countdown <= ctl.us;
    end else if (ctl.step) begin
      prescaler <= prescaler_stepped;
      countdown <= countdown_stepped;
    end
  end

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer: 4-bit character LCD write sequencer
// Turns command, data and power-up requests into RS, E and D7..D4 levels.
// ----------------------------------------------------------------------------
// Each request transfer is one clock tick of pin timing and yields exactly one
// result transfer with the pin levels after that tick, plus busy and a reject
// flag. The block takes one request per cycle; a result shows in the cycle after
// its request and sits in an output register, so a new request is taken while
// the previous result still waits as long as the result side takes it in the
// same cycle. The next-state logic is one short combinational pass from the
// phase registers and the microsecond timer into the state and result
// registers. A command or data request (taken only when idle) sends the high
// then the low nibble, E high 2 us then low 50 us per nibble; commands then
// wait 2000 us for clear and home, 50 us otherwise. Init waits 30 ms, sends
// bare nibbles 3,3,3,2 with 5 ms after each, the commands 0x28, 0x0C, 0x06,
// 0x01, and waits 2 ms more. A request that arrives while busy is dropped and
// flagged as rejected. One microsecond is ticks_per_microsecond request
// transfers (zero acts as one); write that register only while no request
// transfer is due; a new rate applies from the next tick on, also in the
// middle of a sequence.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer
  import lcdnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lcdnw_cfg_if.sink   cfg,
  lcdnw_req_if.sink   req,
  lcdnw_res_if.source res
);

  // Rate register
  logic [TPU_W-1:0] tpu;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [STEP_W-1:0] init_step, init_step_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              is_command, is_command_next;
  logic              low_half_next, low_half_next_next;
  logic              rs_level, rs_level_next;
  logic              e_level, e_level_next;
  logic [3:0]        nibble_level, nibble_level_next;

  // Result register
  logic       out_valid;
  logic       out_rs;
  logic       out_e;
  logic [3:0] out_nibble;
  logic       out_busy;
  logic       out_rej;

  tmr_ctl_t tmr_ctl;
  logic     expired;
  logic     in_fire;
  logic     rej;

  // Scratch for the shared sub-sequences
  logic              do_init;
  logic [STEP_W-1:0] init_s;
  logic              do_byte;
  logic [7:0]        byte_b;
  logic              byte_cmd;
  logic [STEP_W-1:0] step_off;

  // Accept a request whenever the result slot is free or being drained
  assign req.ready = !out_valid || res.ready;
  assign in_fire   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpu <= TPU_RESET;
    end else if (cfg.valid) begin
      tpu <= cfg.ticks_per_microsecond;
    end
  end

  lcdnw_us_timer u_timer (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tmr_ctl),
    .tpu     (tpu),
    .expired (expired)
  );

  // One tick of the sequencer: idle requests start work, otherwise advance the
  // timer and move to the next phase when it runs out.
  always_comb begin
    phase_next         = phase;
    init_step_next     = init_step;
    held_byte_next     = held_byte;
    is_command_next    = is_command;
    low_half_next_next = low_half_next;
    rs_level_next      = rs_level;
    e_level_next       = e_level;
    nibble_level_next  = nibble_level;
    tmr_ctl            = '{step: 1'b0, load: 1'b0, us: US_NONE};
    rej                = 1'b0;
    do_init            = 1'b0;
    init_s             = STEP_NONE;
    do_byte            = 1'b0;
    byte_b             = req.byte_value;
    byte_cmd           = 1'b0;
    step_off           = '0;

    if (phase == PH_IDLE) begin
      case (req.req_type)
        REQ_CMD: begin
          init_step_next = STEP_NONE;
          do_byte        = 1'b1;
          byte_cmd       = 1'b1;
        end
        REQ_DATA: begin
          init_step_next = STEP_NONE;
          do_byte        = 1'b1;
        end
        REQ_INIT: begin
          rs_level_next = 1'b0;
          e_level_next  = 1'b0;
          do_init       = 1'b1;
          init_s        = STEP_POWER_UP;
        end
        default: begin
        end
      endcase
    end else begin
      rej          = (req.req_type != REQ_TICK);
      tmr_ctl.step = 1'b1;
      if (expired) begin
        tmr_ctl.load = 1'b1;
        case (phase)
          PH_BYTE_EH: begin
            e_level_next = 1'b0;
            phase_next   = PH_BYTE_EL;
            tmr_ctl.us   = US_E_LOW;
          end
          PH_BYTE_EL: begin
            if (low_half_next) begin
              low_half_next_next = 1'b0;
              nibble_level_next  = held_byte[3:0];
              e_level_next       = 1'b1;
              phase_next         = PH_BYTE_EH;
              tmr_ctl.us         = US_E_HIGH;
            end else if (is_command) begin
              phase_next = PH_CMD_WAIT;
              tmr_ctl.us = (held_byte == CMD_CLEAR || held_byte == CMD_HOME)
                           ? US_CMD_LONG : US_CMD_SHORT;
            end else if (init_step != STEP_NONE) begin
              do_init = 1'b1;
              init_s  = init_step + STEP_W'(1);
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_CMD_WAIT: begin
            if (init_step != STEP_NONE) begin
              do_init = 1'b1;
              init_s  = init_step + STEP_W'(1);
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_RAW_EH: begin
            e_level_next = 1'b0;
            phase_next   = PH_RAW_EL;
            tmr_ctl.us   = US_E_LOW;
          end
          PH_RAW_EL: begin
            phase_next = PH_INIT_WAIT;
            tmr_ctl.us = US_RAW_SETTLE;
          end
          PH_INIT_WAIT: begin
            do_init = 1'b1;
            init_s  = init_step + STEP_W'(1);
          end
          default: begin
            init_step_next = STEP_NONE;
            e_level_next   = 1'b0;
            phase_next     = PH_IDLE;
          end
        endcase
      end
    end

    // Start one step of the power-up sequence
    if (do_init) begin
      init_step_next = init_s;
      tmr_ctl.load   = 1'b1;
      if (init_s == STEP_POWER_UP) begin
        phase_next = PH_INIT_WAIT;
        tmr_ctl.us = US_POWER_UP;
      end else if (init_s >= STEP_RAW_FIRST && init_s <= STEP_RAW_LAST) begin
        step_off          = init_s - STEP_RAW_FIRST;
        nibble_level_next = init_nib(step_off[1:0]);
        e_level_next      = 1'b1;
        phase_next        = PH_RAW_EH;
        tmr_ctl.us        = US_E_HIGH;
      end else if (init_s >= STEP_CMD_FIRST && init_s <= STEP_CMD_LAST) begin
        step_off = init_s - STEP_CMD_FIRST;
        do_byte  = 1'b1;
        byte_b   = init_cmd(step_off[1:0]);
        byte_cmd = 1'b1;
      end else if (init_s == STEP_TAIL) begin
        phase_next = PH_INIT_WAIT;
        tmr_ctl.us = US_INIT_TAIL;
      end else begin
        init_step_next = STEP_NONE;
        e_level_next   = 1'b0;
        phase_next     = PH_IDLE;
        tmr_ctl.us     = US_NONE;
      end
    end

    // Start a byte: high nibble first, E high
    if (do_byte) begin
      held_byte_next     = byte_b;
      is_command_next    = byte_cmd;
      rs_level_next      = !byte_cmd;
      nibble_level_next  = byte_b[7:4];
      e_level_next       = 1'b1;
      low_half_next_next = 1'b1;
      phase_next         = PH_BYTE_EH;
      tmr_ctl.load       = 1'b1;
      tmr_ctl.us         = US_E_HIGH;
    end

    // Nothing moves without a request transfer
    if (!in_fire) begin
      tmr_ctl.step = 1'b0;
      tmr_ctl.load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      init_step     <= STEP_NONE;
      held_byte     <= '0;
      is_command    <= 1'b0;
      low_half_next <= 1'b0;
      rs_level      <= 1'b0;
      e_level       <= 1'b0;
      nibble_level  <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      init_step     <= init_step_next;
      held_byte     <= held_byte_next;
      is_command    <= is_command_next;
      low_half_next <= low_half_next_next;
      rs_level      <= rs_level_next;
      e_level       <= e_level_next;
      nibble_level  <= nibble_level_next;
    end
  end

  // Result slot: load on every request transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_rs     <= rs_level_next;
      out_e      <= e_level_next;
      out_nibble <= nibble_level_next;
      out_busy   <= (phase_next != PH_IDLE);
      out_rej    <= rej;
    end
  end

  assign res.valid          = out_valid;
  assign res.reg_select_pin = out_rs;
  assign res.enable_pin     = out_e;
  assign res.data_nibble    = out_nibble;
  assign res.busy_res       = out_busy;
  assign res.rejected       = out_rej;

`ifndef SYNTHESIS
  a_req_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && req.req_type != REQ_TICK |=> phase != PH_IDLE)
    else $error("request taken in idle did not start a sequence");

  a_e_only_in_strobe: assert property (@(posedge clk) disable iff (rst)
    e_level |-> (phase == PH_BYTE_EH || phase == PH_RAW_EH))
    else $error("E high outside a strobe phase");

  a_idle_no_init: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> init_step == STEP_NONE)
    else $error("idle with an init step pending");

  a_busy_rejects: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase != PH_IDLE && req.req_type != REQ_TICK |=> out_rej)
    else $error("request while busy not flagged as rejected");
`endif

endmodule
